// ===== design/cle_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cle_pkg: shared definitions for the cursor list engine
// Field widths, command and status codes, controller states and the
// command/status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package cle_pkg;

    // Default sizing of the list store.
    localparam int CAPACITY_DEF   = 64;
    localparam int DATA_WIDTH_DEF = 32;

    // Fixed widths of the item fields on the channels.
    localparam int CMD_W    = 4;
    localparam int VALUE_W  = 32;
    localparam int POS_W    = 6;
    localparam int STATUS_W = 2;
    localparam int IDX_W    = 6;
    localparam int SIZE_W   = 7;

    // Command codes; the remaining codes are no-operations.
    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT = 4'd0,
        CMD_APPEND = 4'd1,
        CMD_ERASE  = 4'd2,
        CMD_BEGIN  = 4'd3,
        CMD_END    = 4'd4,
        CMD_PREV   = 4'd5,
        CMD_NEXT   = 4'd6,
        CMD_SETPOS = 4'd7,
        CMD_READ   = 4'd8,
        CMD_FIND   = 4'd9,
        CMD_CLEAR  = 4'd10
    } t_cmd;

    // Result status codes.
    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_EMPTY    = 2'd1,
        ST_FULL     = 2'd2,
        ST_NOTFOUND = 2'd3
    } t_status;

    // Controller states.
    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_FINISH
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;    // capture the accepted item and set up the walk
        logic step;    // issue one memory read of the walk
        logic commit;  // update count and cursor, load the result register
    } t_dp_ctrl;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic more;    // another memory read is needed
        logic pend;    // a read issued last cycle is still being handled
    } t_dp_stat;

endpackage

// ===== design/cle_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cle_in_if: command channel of the cursor list engine
// Carries one command item with valid/ready flow control.
// ----------------------------------------------------------------------------
interface cle_in_if;
    logic                          valid;
    logic                          ready;
    logic [cle_pkg::CMD_W-1:0]     command;
    logic [cle_pkg::VALUE_W-1:0]   value;
    logic [cle_pkg::POS_W-1:0]     position;

    modport source (output valid, command, value, position, input ready);
    modport sink   (input valid, command, value, position, output ready);
endinterface

// ===== design/cle_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cle_out_if: result channel of the cursor list engine
// Carries one result item with valid/ready flow control.
// ----------------------------------------------------------------------------
interface cle_out_if;
    logic                           valid;
    logic                           ready;
    logic [cle_pkg::STATUS_W-1:0]   status;
    logic [cle_pkg::VALUE_W-1:0]    read_value;
    logic [cle_pkg::IDX_W-1:0]      found_index;
    logic [cle_pkg::SIZE_W-1:0]     list_size;
    logic [cle_pkg::IDX_W-1:0]      cursor;

    modport source (output valid, status, read_value, found_index, list_size, cursor,
                    input ready);
    modport sink   (input valid, status, read_value, found_index, list_size, cursor,
                    output ready);
endinterface

// ===== design/cle_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cle_ctrl: sequencing controller of the cursor list engine
// Accepts one command item at a time, runs the memory walk for the commands
// that need one, and hands the result to the output register.
// ----------------------------------------------------------------------------
module cle_ctrl (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic [cle_pkg::CMD_W-1:0]  i_in_command,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output cle_pkg::t_dp_ctrl          o_ctrl,
    input  cle_pkg::t_dp_stat          i_stat
);

    cle_pkg::t_state r_state, n_state;
    logic            r_out_valid, n_out_valid;
    logic            w_walk;

    // Commands that walk through the store before they can finish.
    always_comb begin
        unique case (cle_pkg::t_cmd'(i_in_command)) inside
            cle_pkg::CMD_INSERT, cle_pkg::CMD_ERASE,
            cle_pkg::CMD_READ, cle_pkg::CMD_FIND: w_walk = 1'b1;
            default:                               w_walk = 1'b0;
        endcase
    end

    // State and output valid registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= cle_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // Next state and datapath commands.
    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        o_ctrl      = '0;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            cle_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    o_ctrl.load = 1'b1;
                    n_state     = w_walk ? cle_pkg::S_WALK : cle_pkg::S_FINISH;
                end
            end
            cle_pkg::S_WALK: begin
                o_ctrl.step = i_stat.more;
                if (!i_stat.more && !i_stat.pend) begin
                    n_state = cle_pkg::S_FINISH;
                end
            end
            cle_pkg::S_FINISH: begin
                // The result register may be loaded once the previous item has left.
                if (!r_out_valid || i_out_ready) begin
                    o_ctrl.commit = 1'b1;
                    n_out_valid   = 1'b1;
                    n_state       = cle_pkg::S_IDLE;
                end
            end
            default: n_state = cle_pkg::S_IDLE;
        endcase
    end

    assign o_in_ready  = (r_state == cle_pkg::S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

// ===== design/cle_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cle_dp: datapath of the cursor list engine
// Holds the list memory, entry count and cursor, walks the memory one entry
// per cycle for shifts, reads and searches, and builds the result item.
// ----------------------------------------------------------------------------
module cle_dp #(
    parameter int CAPACITY   = cle_pkg::CAPACITY_DEF,
    parameter int DATA_WIDTH = cle_pkg::DATA_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  cle_pkg::t_dp_ctrl             i_ctrl,
    output cle_pkg::t_dp_stat             o_stat,
    input  logic [cle_pkg::CMD_W-1:0]     i_command,
    input  logic [cle_pkg::VALUE_W-1:0]   i_value,
    input  logic [cle_pkg::POS_W-1:0]     i_position,
    output cle_pkg::t_status              o_status,
    output logic [cle_pkg::VALUE_W-1:0]   o_read_value,
    output logic [cle_pkg::IDX_W-1:0]     o_found_index,
    output logic [cle_pkg::SIZE_W-1:0]    o_list_size,
    output logic [cle_pkg::IDX_W-1:0]     o_cursor
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int PW = (CW > cle_pkg::POS_W) ? CW : cle_pkg::POS_W;

    // List store and its registered read data.
    logic [DATA_WIDTH-1:0] mem [CAPACITY];
    logic [DATA_WIDTH-1:0] r_rdata;

    // List state.
    logic [CW-1:0]         r_count, n_count;
    logic [AW-1:0]         r_cursor, n_cursor;

    // Captured item and walk state.
    logic [cle_pkg::CMD_W-1:0] r_cmd;
    logic [DATA_WIDTH-1:0]     r_val;
    logic [cle_pkg::POS_W-1:0] r_pos;
    logic [CW-1:0]             r_idx;
    logic                      r_pend_wr, r_pend_cap, r_pend_cmp;
    logic [AW-1:0]             r_raddr_q;
    logic [AW-1:0]             r_wdst;
    logic [DATA_WIDTH-1:0]     r_cap;
    logic                      r_hit;
    logic [AW-1:0]             r_find_idx;

    // Result register.
    cle_pkg::t_status              r_status;
    logic [cle_pkg::VALUE_W-1:0]   r_rd_out;
    logic [cle_pkg::IDX_W-1:0]     r_found;
    logic [cle_pkg::SIZE_W-1:0]    r_size;
    logic [cle_pkg::IDX_W-1:0]     r_cur_out;

    logic                  w_full;
    logic [CW-1:0]         w_cur_ext, w_cur_p1, w_idx_m1, w_idx_p1;
    logic [CW-1:0]         w_count_m1, w_count_m2;
    logic                  w_more, w_is_insert, w_first;
    logic [AW-1:0]         w_raddr;
    logic                  w_we;
    logic [AW-1:0]         w_waddr;
    logic [DATA_WIDTH-1:0] w_wdata;
    logic                  w_commit_wr;
    logic [AW-1:0]         w_commit_addr;
    cle_pkg::t_status      w_status;
    logic [DATA_WIDTH-1:0] w_rd;
    logic [AW-1:0]         w_found;

    assign w_full      = (r_count == CW'(CAPACITY));
    assign w_cur_ext   = CW'(r_cursor);
    assign w_cur_p1    = w_cur_ext + CW'(1);
    assign w_idx_m1    = r_idx - CW'(1);
    assign w_idx_p1    = r_idx + CW'(1);
    assign w_count_m1  = r_count - CW'(1);
    assign w_count_m2  = r_count - CW'(2);
    assign w_is_insert = (cle_pkg::t_cmd'(r_cmd) == cle_pkg::CMD_INSERT);
    assign w_first     = (r_idx == w_cur_ext);

    // Whether the walk needs another read. Insert walks down from the end to
    // the cursor, erase walks up from the cursor, find walks up from the front.
    always_comb begin
        unique case (cle_pkg::t_cmd'(r_cmd))
            cle_pkg::CMD_INSERT: w_more = !w_full && (r_idx > w_cur_ext);
            cle_pkg::CMD_ERASE:  w_more = (r_idx < r_count);
            cle_pkg::CMD_READ:   w_more = w_first;
            cle_pkg::CMD_FIND:   w_more = !r_hit && (r_idx < r_count);
            default:             w_more = 1'b0;
        endcase
    end

    assign w_raddr     = w_is_insert ? AW'(w_idx_m1) : AW'(r_idx);
    assign o_stat.more = w_more;
    assign o_stat.pend = r_pend_wr || r_pend_cap || r_pend_cmp;

    // Next list state and result fields at the end of a command.
    always_comb begin
        n_count       = r_count;
        n_cursor      = r_cursor;
        w_status      = cle_pkg::ST_OK;
        w_rd          = '0;
        w_found       = '0;
        w_commit_wr   = 1'b0;
        w_commit_addr = r_cursor;
        unique case (cle_pkg::t_cmd'(r_cmd))
            cle_pkg::CMD_INSERT: begin
                if (w_full) begin
                    w_status = cle_pkg::ST_FULL;
                end else begin
                    w_commit_wr = 1'b1;
                    n_count     = r_count + CW'(1);
                end
            end
            cle_pkg::CMD_APPEND: begin
                if (w_full) begin
                    w_status = cle_pkg::ST_FULL;
                end else begin
                    w_commit_wr   = 1'b1;
                    w_commit_addr = AW'(r_count);
                    n_count       = r_count + CW'(1);
                end
            end
            cle_pkg::CMD_ERASE: begin
                if (r_count == '0) begin
                    w_status = cle_pkg::ST_EMPTY;
                end else begin
                    w_rd    = r_cap;
                    n_count = w_count_m1;
                    // The cursor falls back when it was on the last entry.
                    if (w_cur_ext == w_count_m1) begin
                        n_cursor = (w_count_m1 == '0) ? '0 : AW'(w_count_m2);
                    end
                end
            end
            cle_pkg::CMD_BEGIN: n_cursor = '0;
            cle_pkg::CMD_END:   n_cursor = (r_count == '0) ? '0 : AW'(w_count_m1);
            cle_pkg::CMD_PREV: begin
                if (r_cursor != '0 && r_count != '0) begin
                    n_cursor = r_cursor - AW'(1);
                end
            end
            cle_pkg::CMD_NEXT: begin
                if (r_count != '0 && w_cur_p1 != r_count) begin
                    n_cursor = AW'(w_cur_p1);
                end
            end
            cle_pkg::CMD_SETPOS: begin
                if (PW'(r_pos) < PW'(r_count)) begin
                    n_cursor = AW'(r_pos);
                end
            end
            cle_pkg::CMD_READ: begin
                if (r_count == '0) begin
                    w_status = cle_pkg::ST_EMPTY;
                end else begin
                    w_rd = r_cap;
                end
            end
            cle_pkg::CMD_FIND: begin
                if (r_hit) begin
                    w_found = r_find_idx;
                end else begin
                    w_status = cle_pkg::ST_NOTFOUND;
                end
            end
            cle_pkg::CMD_CLEAR: begin
                n_count  = '0;
                n_cursor = '0;
            end
            default: ;
        endcase
    end

    // Single write port: shift writes during the walk, the new word at commit.
    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_wdst;
        w_wdata = r_rdata;
        if (r_pend_wr) begin
            w_we = 1'b1;
        end else if (i_ctrl.commit && w_commit_wr) begin
            w_we    = 1'b1;
            w_waddr = w_commit_addr;
            w_wdata = r_val;
        end
    end

    // List memory with registered read.
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[w_waddr] <= w_wdata;
        end
        if (i_ctrl.step) begin
            r_rdata <= mem[w_raddr];
        end
    end

    // Control state of the list and the walk.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_cursor   <= '0;
            r_pend_wr  <= 1'b0;
            r_pend_cap <= 1'b0;
            r_pend_cmp <= 1'b0;
            r_hit      <= 1'b0;
        end else begin
            r_pend_wr  <= 1'b0;
            r_pend_cap <= 1'b0;
            r_pend_cmp <= 1'b0;
            if (i_ctrl.load) begin
                r_hit <= 1'b0;
            end
            // Each read is tagged with what its data will be used for.
            if (i_ctrl.step) begin
                unique case (cle_pkg::t_cmd'(r_cmd))
                    cle_pkg::CMD_INSERT: r_pend_wr  <= 1'b1;
                    cle_pkg::CMD_ERASE: begin
                        r_pend_wr  <= !w_first;
                        r_pend_cap <= w_first;
                    end
                    cle_pkg::CMD_READ:   r_pend_cap <= 1'b1;
                    cle_pkg::CMD_FIND:   r_pend_cmp <= 1'b1;
                    default: ;
                endcase
            end
            // The first match wins; later compares are ignored.
            if (r_pend_cmp && !r_hit && (r_rdata == r_val)) begin
                r_hit <= 1'b1;
            end
            if (i_ctrl.commit) begin
                r_count  <= n_count;
                r_cursor <= n_cursor;
            end
        end
    end

    // Item capture, walk pointer and result payload.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_cmd <= i_command;
            r_val <= DATA_WIDTH'(i_value);
            r_pos <= i_position;
            unique case (cle_pkg::t_cmd'(i_command))
                cle_pkg::CMD_INSERT: r_idx <= r_count;
                cle_pkg::CMD_FIND:   r_idx <= '0;
                default:             r_idx <= w_cur_ext;
            endcase
        end else if (i_ctrl.step) begin
            r_idx <= w_is_insert ? w_idx_m1 : w_idx_p1;
        end
        if (i_ctrl.step) begin
            r_raddr_q <= w_raddr;
            r_wdst    <= w_is_insert ? AW'(r_idx) : AW'(w_idx_m1);
        end
        if (r_pend_cap) begin
            r_cap <= r_rdata;
        end
        if (r_pend_cmp && !r_hit && (r_rdata == r_val)) begin
            r_find_idx <= r_raddr_q;
        end
        if (i_ctrl.commit) begin
            r_status  <= w_status;
            r_rd_out  <= cle_pkg::VALUE_W'(w_rd);
            r_found   <= cle_pkg::IDX_W'(w_found);
            r_size    <= cle_pkg::SIZE_W'(n_count);
            r_cur_out <= cle_pkg::IDX_W'(n_cursor);
        end
    end

    assign o_status      = r_status;
    assign o_read_value  = r_rd_out;
    assign o_found_index = r_found;
    assign o_list_size   = r_size;
    assign o_cursor      = r_cur_out;

endmodule

// ===== design/cursor_list_engine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cursor_list_engine: ordered word list with a cursor
// The engine keeps up to CAPACITY words in a list memory with one read and
// one write port and runs one command item at a time, giving one result item
// for each. Insert and erase shift the entries from the cursor to the end of
// the list, with nothing to shift on an empty list or on an insert into a
// full list; read fetches the entry at the cursor, and find searches from
// the front up to the first match. The walk moves one entry per cycle
// through the memory's one read and one write port. A new item is accepted
// in the cycle after the result is written to the output register, while
// that result may still wait to be taken. There is no clearing pass after
// reset.
// ----------------------------------------------------------------------------
module cursor_list_engine #(
    parameter int CAPACITY   = cle_pkg::CAPACITY_DEF,
    parameter int DATA_WIDTH = cle_pkg::DATA_WIDTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    cle_in_if.sink        i_cmd,
    cle_out_if.source     o_res
);

    cle_pkg::t_dp_ctrl w_ctrl;
    cle_pkg::t_dp_stat w_stat;
    cle_pkg::t_status  w_status;

    // Sequencing.
    cle_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_cmd.valid),
        .o_in_ready   (i_cmd.ready),
        .i_in_command (i_cmd.command),
        .o_out_valid  (o_res.valid),
        .i_out_ready  (o_res.ready),
        .o_ctrl       (w_ctrl),
        .i_stat       (w_stat)
    );

    // Storage and arithmetic.
    cle_dp #(
        .CAPACITY   (CAPACITY),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctrl        (w_ctrl),
        .o_stat        (w_stat),
        .i_command     (i_cmd.command),
        .i_value       (i_cmd.value),
        .i_position    (i_cmd.position),
        .o_status      (w_status),
        .o_read_value  (o_res.read_value),
        .o_found_index (o_res.found_index),
        .o_list_size   (o_res.list_size),
        .o_cursor      (o_res.cursor)
    );

    assign o_res.status = w_status;

endmodule

// ===== design/cle_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cle_checker: port-level checks for the cursor list engine
// Watches the channels of the top level and flags behaviour that the engine
// must never show; attached to every instance of the top level.
// ----------------------------------------------------------------------------
module cle_checker #(
    parameter int CAPACITY = cle_pkg::CAPACITY_DEF
) (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_in_valid,
    input logic                           i_in_ready,
    input logic                           i_out_valid,
    input logic                           i_out_ready,
    input logic [cle_pkg::STATUS_W-1:0]   i_status,
    input logic [cle_pkg::VALUE_W-1:0]    i_read_value,
    input logic [cle_pkg::IDX_W-1:0]      i_found_index,
    input logic [cle_pkg::SIZE_W-1:0]     i_list_size,
    input logic [cle_pkg::IDX_W-1:0]      i_cursor
);

    // A stalled result item holds still.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_status)
            && $stable(i_read_value) && $stable(i_found_index)
            && $stable(i_list_size) && $stable(i_cursor))
        else $error("result item changed while stalled");

    // Only one item is in work at a time.
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("second item accepted while one is in work");

    // A full status is only reported on a full list.
    a_full_size: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_status == cle_pkg::ST_FULL)
            |-> (i_list_size == cle_pkg::SIZE_W'(CAPACITY)))
        else $error("full status with a list that is not full");

    // The cursor stays inside a list that holds entries.
    a_cursor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (CAPACITY <= 64) && i_out_valid && (i_list_size != '0)
            |-> (cle_pkg::SIZE_W'(i_cursor) < i_list_size))
        else $error("cursor beyond the last entry");

endmodule

bind cursor_list_engine cle_checker #(
    .CAPACITY (CAPACITY)
) u_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_cmd.valid),
    .i_in_ready    (i_cmd.ready),
    .i_out_valid   (o_res.valid),
    .i_out_ready   (o_res.ready),
    .i_status      (o_res.status),
    .i_read_value  (o_res.read_value),
    .i_found_index (o_res.found_index),
    .i_list_size   (o_res.list_size),
    .i_cursor      (o_res.cursor)
);
